[rtl/mame_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and helpers for the matrix add/multiply engine
// no dependencies; used by every rtl file of the block
package mame_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int MEM_DEPTH  = MAX_DIM * MAX_DIM;
    localparam int DIM_W      = 4;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int NUM_CFG    = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [2:0] OP_WRITE_A = 3'd0;
    localparam logic [2:0] OP_WRITE_B = 3'd1;
    localparam logic [2:0] OP_READ_A  = 3'd2;
    localparam logic [2:0] OP_READ_B  = 3'd3;
    localparam logic [2:0] OP_ADD     = 3'd4;
    localparam logic [2:0] OP_MUL     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef enum logic [2:0] {
        CMD_WRITE_A,
        CMD_WRITE_B,
        CMD_READ_A,
        CMD_READ_B,
        CMD_ADD,
        CMD_MAC,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        logic                valid;
        cmd_kind_t           kind;
        logic [ADDR_W-1:0]   addr_a;
        logic [ADDR_W-1:0]   addr_b;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [STATUS_W-1:0] status;
        logic                first;
        logic                last_k;
        logic                last_item;
        data_t               wdata;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } dp_status_t;

    // highest usable index for a shape register, with 0 read as 1 and overrange clamped
    function automatic logic [IDX_W-1:0] dim_lim(input logic [DIM_W-1:0] dim);
        logic [IDX_W-1:0] lim;
        if (dim == '0)
        begin
            lim = '0;
        end
        else if (dim > DIM_W'(MAX_DIM))
        begin
            lim = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            lim = IDX_W'(dim - 1'b1);
        end
        return lim;
    endfunction

endpackage

[rtl/mame_ctrl.sv]
`timescale 1ns / 1ps
// controller: shape registers, command decode, checks and index sequencing
// depends on mame_pkg; drives the datapath through mame_pkg::cmd_t
module mame_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [2:0]                     opcode,
    input  logic [3:0]                     row,
    input  logic [3:0]                     col,
    input  logic signed [31:0]             value,
    input  logic                           cfg_we,
    input  logic [mame_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mame_pkg::DIM_W-1:0]     cfg_data,
    input  mame_pkg::dp_status_t           dp_status,
    output mame_pkg::cmd_t                 cmd,
    output logic                           busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t                        state_reg, state_next;
    mame_pkg::cmd_t                cmd_reg, cmd_next;
    logic [mame_pkg::DIM_W-1:0]    cfg_reg [mame_pkg::NUM_CFG];
    logic [mame_pkg::IDX_W-1:0]    i_reg, i_next;
    logic [mame_pkg::IDX_W-1:0]    j_reg, j_next;
    logic [mame_pkg::IDX_W-1:0]    k_reg, k_next;
    logic                          mul_reg, mul_next;

    logic [mame_pkg::IDX_W-1:0]    ar_lim, ac_lim, br_lim, bc_lim;
    logic [mame_pkg::IDX_W-1:0]    rl, cl, j_lim;
    logic                          oob;
    logic                          k_done, j_done, i_done;

    assign ar_lim = mame_pkg::dim_lim(cfg_reg[mame_pkg::CFG_A_ROWS]);
    assign ac_lim = mame_pkg::dim_lim(cfg_reg[mame_pkg::CFG_A_COLS]);
    assign br_lim = mame_pkg::dim_lim(cfg_reg[mame_pkg::CFG_B_ROWS]);
    assign bc_lim = mame_pkg::dim_lim(cfg_reg[mame_pkg::CFG_B_COLS]);

    assign rl    = opcode[0] ? br_lim : ar_lim;
    assign cl    = opcode[0] ? bc_lim : ac_lim;
    assign oob   = (row > {1'b0, rl}) || (col > {1'b0, cl});
    assign j_lim = mul_reg ? bc_lim : ac_lim;

    assign k_done = !mul_reg || (k_reg == ac_lim);
    assign j_done = k_done && (j_reg == j_lim);
    assign i_done = j_done && (i_reg == ar_lim);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        mul_next   = mul_reg;
        cmd_next   = '0;
        cmd_next.kind   = mame_pkg::CMD_ERR;
        cmd_next.status = mame_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    i_next = '0;
                    j_next = '0;
                    k_next = '0;
                    unique case (opcode) inside
                        mame_pkg::OP_WRITE_A, mame_pkg::OP_WRITE_B,
                        mame_pkg::OP_READ_A, mame_pkg::OP_READ_B:
                        begin
                            cmd_next.valid     = 1'b1;
                            cmd_next.last_item = 1'b1;
                            state_next         = S_DRAIN;
                            if (oob)
                            begin
                                cmd_next.kind   = mame_pkg::CMD_ERR;
                                cmd_next.status = mame_pkg::ST_RANGE;
                            end
                            else
                            begin
                                unique case (opcode) inside
                                    mame_pkg::OP_WRITE_A: cmd_next.kind = mame_pkg::CMD_WRITE_A;
                                    mame_pkg::OP_WRITE_B: cmd_next.kind = mame_pkg::CMD_WRITE_B;
                                    mame_pkg::OP_READ_A:  cmd_next.kind = mame_pkg::CMD_READ_A;
                                    default:              cmd_next.kind = mame_pkg::CMD_READ_B;
                                endcase
                                cmd_next.addr_a = {row[mame_pkg::IDX_W-1:0],
                                                   col[mame_pkg::IDX_W-1:0]};
                                cmd_next.addr_b = cmd_next.addr_a;
                                cmd_next.row    = row[mame_pkg::IDX_W-1:0];
                                cmd_next.col    = col[mame_pkg::IDX_W-1:0];
                                cmd_next.wdata  = mame_pkg::DATA_WIDTH'(value);
                            end
                        end
                        mame_pkg::OP_ADD:
                        begin
                            if (ar_lim != br_lim || ac_lim != bc_lim)
                            begin
                                cmd_next.valid     = 1'b1;
                                cmd_next.last_item = 1'b1;
                                cmd_next.status    = mame_pkg::ST_MISMATCH;
                                state_next         = S_DRAIN;
                            end
                            else
                            begin
                                mul_next   = 1'b0;
                                state_next = S_RUN;
                            end
                        end
                        mame_pkg::OP_MUL:
                        begin
                            if (ac_lim != br_lim)
                            begin
                                cmd_next.valid     = 1'b1;
                                cmd_next.last_item = 1'b1;
                                cmd_next.status    = mame_pkg::ST_MISMATCH;
                                state_next         = S_DRAIN;
                            end
                            else
                            begin
                                mul_next   = 1'b1;
                                state_next = S_RUN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                cmd_next.valid     = 1'b1;
                cmd_next.kind      = mul_reg ? mame_pkg::CMD_MAC : mame_pkg::CMD_ADD;
                cmd_next.row       = i_reg;
                cmd_next.col       = j_reg;
                cmd_next.addr_a    = mul_reg ? {i_reg, k_reg} : {i_reg, j_reg};
                cmd_next.addr_b    = mul_reg ? {k_reg, j_reg} : {i_reg, j_reg};
                cmd_next.first     = (k_reg == '0);
                cmd_next.last_k    = k_done;
                cmd_next.last_item = i_done;
                if (i_done)
                begin
                    state_next = S_DRAIN;
                end
                else if (j_done)
                begin
                    k_next = '0;
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                end
                else if (k_done)
                begin
                    k_next = '0;
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!cmd_reg.valid && !dp_status.pipe_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            mul_reg   <= 1'b0;
            for (int n = 0; n < mame_pkg::NUM_CFG; n++)
            begin
                cfg_reg[n] <= mame_pkg::DIM_RESET;
            end
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            mul_reg   <= mul_next;
            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
        end
    end

    assign cmd  = cmd_reg;
    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/mame_datapath.sv]
`timescale 1ns / 1ps
// datapath: matrix stores, multiply/add pipeline, accumulator and result register
// depends on mame_pkg; takes commands from mame_ctrl
module mame_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mame_pkg::cmd_t                    cmd,
    output mame_pkg::dp_status_t              dp_status,
    output logic                              result_valid,
    output logic [mame_pkg::IDX_W-1:0]        row_res,
    output logic [mame_pkg::IDX_W-1:0]        col_res,
    output logic signed [mame_pkg::VALUE_W-1:0] value_res,
    output logic [mame_pkg::STATUS_W-1:0]     status,
    output logic                              last
);

    logic [mame_pkg::DATA_WIDTH-1:0] mem_a [mame_pkg::MEM_DEPTH];
    logic [mame_pkg::DATA_WIDTH-1:0] mem_b [mame_pkg::MEM_DEPTH];
    logic [mame_pkg::MEM_DEPTH-1:0]  va_bits_reg;
    logic [mame_pkg::MEM_DEPTH-1:0]  vb_bits_reg;

    mame_pkg::cmd_t                  s1_reg;
    mame_pkg::cmd_t                  s2_reg;
    logic [mame_pkg::DATA_WIDTH-1:0] rd_a_reg;
    logic [mame_pkg::DATA_WIDTH-1:0] rd_b_reg;
    logic                            va_reg;
    logic                            vb_reg;
    mame_pkg::data_t                 res_reg, res_next;
    mame_pkg::data_t                 acc_reg, acc_next;
    mame_pkg::data_t                 a_val, b_val;
    mame_pkg::data_t                 out_val;

    logic                               out_valid_reg;
    logic [mame_pkg::IDX_W-1:0]         out_row_reg;
    logic [mame_pkg::IDX_W-1:0]         out_col_reg;
    logic signed [mame_pkg::VALUE_W-1:0] out_value_reg;
    logic [mame_pkg::STATUS_W-1:0]      out_status_reg;
    logic                               out_last_reg;

    logic wr_a, wr_b;

    assign wr_a = cmd.valid && (cmd.kind == mame_pkg::CMD_WRITE_A);
    assign wr_b = cmd.valid && (cmd.kind == mame_pkg::CMD_WRITE_B);

    // stores, one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[cmd.addr_a] <= cmd.wdata;
        end
        if (wr_b)
        begin
            mem_b[cmd.addr_b] <= cmd.wdata;
        end
        rd_a_reg <= mem_a[cmd.addr_a];
        rd_b_reg <= mem_b[cmd.addr_b];
    end

    assign a_val = va_reg ? rd_a_reg : '0;
    assign b_val = vb_reg ? rd_b_reg : '0;

    always_comb
    begin
        case (s1_reg.kind) inside
            mame_pkg::CMD_WRITE_A, mame_pkg::CMD_WRITE_B: res_next = s1_reg.wdata;
            mame_pkg::CMD_READ_A:                         res_next = a_val;
            mame_pkg::CMD_READ_B:                         res_next = b_val;
            mame_pkg::CMD_ADD:                            res_next = a_val + b_val;
            mame_pkg::CMD_MAC:                            res_next = a_val * b_val;
            default:                                      res_next = '0;
        endcase
    end

    assign acc_next = s2_reg.first ? res_reg : acc_reg + res_reg;
    assign out_val  = (s2_reg.kind == mame_pkg::CMD_MAC) ? acc_next : res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_bits_reg    <= '0;
            vb_bits_reg    <= '0;
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            s1_reg         <= '0;
            s2_reg         <= '0;
            res_reg        <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_value_reg  <= '0;
            out_status_reg <= mame_pkg::ST_OK;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // entry written since reset; a clear entry reads as zero
            if (wr_a)
            begin
                va_bits_reg[cmd.addr_a] <= 1'b1;
            end
            if (wr_b)
            begin
                vb_bits_reg[cmd.addr_b] <= 1'b1;
            end
            va_reg  <= va_bits_reg[cmd.addr_a];
            vb_reg  <= vb_bits_reg[cmd.addr_b];
            s1_reg  <= cmd;
            s2_reg  <= s1_reg;
            res_reg <= res_next;
            if (s2_reg.valid && s2_reg.kind == mame_pkg::CMD_MAC)
            begin
                acc_reg <= acc_next;
            end
            out_valid_reg  <= s2_reg.valid &&
                              (s2_reg.kind != mame_pkg::CMD_MAC || s2_reg.last_k);
            out_row_reg    <= s2_reg.row;
            out_col_reg    <= s2_reg.col;
            out_value_reg  <= mame_pkg::VALUE_W'(out_val);
            out_status_reg <= s2_reg.status;
            out_last_reg   <= s2_reg.last_item;
        end
    end

    assign dp_status.pipe_busy = s1_reg.valid || s2_reg.valid;

    assign result_valid = out_valid_reg;
    assign row_res      = out_row_reg;
    assign col_res      = out_col_reg;
    assign value_res    = out_value_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;

endmodule

[rtl/matrix_add_multiply_engine.sv]
`timescale 1ns / 1ps
// read/write: one result, marked last; the next item is accepted only once the pipeline has drained
// add: ar*ac results, one per cycle; busy until the pipeline drains
// multiply: one multiply-accumulate unit, ar*bc*ac steps; busy until the pipeline drains
// reset: shapes 8x8, both stores read as zero through per-entry valid bits; no clearing pass
// results are shown for one cycle each; the receiver cannot stall
// top level of the matrix engine; depends on mame_pkg, mame_ctrl, mame_datapath
module matrix_add_multiply_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     opcode,
    input  logic [3:0]                     row,
    input  logic [3:0]                     col,
    input  logic signed [31:0]             value,
    input  logic                           cfg_we,
    input  logic [mame_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mame_pkg::DIM_W-1:0]     cfg_data,
    output logic                           result_valid,
    output logic [2:0]                     row_res,
    output logic [2:0]                     col_res,
    output logic signed [31:0]             value_res,
    output logic [1:0]                     status,
    output logic                           last
);

    mame_pkg::cmd_t       cmd;
    mame_pkg::dp_status_t dp_status;

    mame_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .row       (row),
        .col       (col),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy)
    );

    mame_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_status    (dp_status),
        .result_valid (result_valid),
        .row_res      (row_res),
        .col_res      (col_res),
        .value_res    (value_res),
        .status       (status),
        .last         (last)
    );

endmodule

[rtl/mame_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the matrix engine, bound to the top level
// depends on mame_pkg and matrix_add_multiply_engine
module mame_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [2:0]        opcode,
    input logic              result_valid,
    input logic [2:0]        row_res,
    input logic [2:0]        col_res,
    input logic signed [31:0] value_res,
    input logic [1:0]        status,
    input logic              last
);

    logic mem_op;

    assign mem_op = (opcode == mame_pkg::OP_WRITE_A) || (opcode == mame_pkg::OP_WRITE_B) ||
                    (opcode == mame_pkg::OP_READ_A) || (opcode == mame_pkg::OP_READ_B);

    // results only come while an item is in flight
    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside busy window");

    // error results are single items with zero payload
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != mame_pkg::ST_OK) |->
            (last && row_res == 3'd0 && col_res == 3'd0 && value_res == 32'sd0))
        else $error("error result malformed");

    // a read or write gives its one result, marked last, after accept
    a_mem_op_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mem_op) |-> ##4 (result_valid && last))
        else $error("read/write result missing");

    // an accepted add or multiply keeps the block busy
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == mame_pkg::OP_ADD || opcode == mame_pkg::OP_MUL))
            |=> busy)
        else $error("busy not raised");

endmodule

bind matrix_add_multiply_engine mame_checker u_mame_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .result_valid (result_valid),
    .row_res      (row_res),
    .col_res      (col_res),
    .value_res    (value_res),
    .status       (status),
    .last         (last)
);
